// File: src/sorted_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted_timer_queue_assert.svh : assertion macros
// Shared concurrent-assertion templates for the timer queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define STQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_timer_queue: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_timer_queue: next-cycle check failed");

`endif

// File: src/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg : sorted timer queue shared definitions
// Field widths, action and result codes, cell control and cell contents.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int TIME_WIDTH_DEF = 48;

    localparam int ACTION_W = 2;
    localparam int TIME_W   = 48;
    localparam int ID_W     = 31;
    localparam int TAG_W    = 16;
    localparam int KIND_W   = 3;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 48;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    localparam logic [ACTION_W-1:0] ACT_SET    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SET     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BADID   = 3'd5;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_EVAL,
        OP_INSERT,
        OP_REMOVE,
        OP_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     by_id;
    } t_cell_ctrl;

    typedef struct packed {
        logic             valid;
        logic             flag;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } t_cell_info;

endpackage

// File: src/sorted_timer_queue.sv
// Each accepted word is first evaluated into the cell flags; the act step then writes any
// result word, holding while the result register still waits on the receiver. A word is
// taken only in idle, so the next one waits until the last is done; a tick pops expired
// timers off the head, one result per cycle while the receiver keeps up (a single one if none).
// Reset clears all valid bits, the id counter and the output valid bit at once;
// no clearing pass is needed, and the first word is taken right after reset.
// ----------------------------------------------------------------------------
// sorted_timer_queue : sorted timer list with set, cancel and tick
// A chain of DEPTH cells kept in expiry order; the head is the earliest timer.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_assert.svh"

module sorted_timer_queue #(
    parameter int DEPTH      = stq_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = stq_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: expire_time[47:0], timer_id[78:48], user_tag[94:79], now_time[142:95], zero
    input  logic [stq_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: action[1:0]
    input  logic [stq_pkg::ACTION_W-1:0]      i_s_tuser,
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: out_id[30:0], out_tag[46:31], found[47]
    output logic [stq_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: kind[2:0]
    output logic [stq_pkg::KIND_W-1:0]        o_m_tuser,
    output logic                              o_m_tlast
);

    typedef enum logic {
        S_IDLE,
        S_ACT
    } t_state;

    t_state r_state;

    // input field unpacking
    logic [stq_pkg::TIME_W-1:0] w_in_etime;
    logic [stq_pkg::ID_W-1:0]   w_in_id;
    logic [stq_pkg::TAG_W-1:0]  w_in_tag;
    logic [stq_pkg::TIME_W-1:0] w_in_now;
    logic [TIME_WIDTH-1:0]      w_etime;
    logic [TIME_WIDTH-1:0]      w_now;

    assign w_in_etime = i_s_tdata[47:0];
    assign w_in_id    = i_s_tdata[78:48];
    assign w_in_tag   = i_s_tdata[94:79];
    assign w_in_now   = i_s_tdata[142:95];

    // take times in their low TIME_WIDTH bits, zero-extend if wider
    assign w_etime = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, w_in_etime});
    assign w_now   = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, w_in_now});

    // latched item
    logic [stq_pkg::ACTION_W-1:0] r_action;
    logic [TIME_WIDTH-1:0]        r_etime;
    logic [stq_pkg::ID_W-1:0]     r_tid;
    logic [stq_pkg::TAG_W-1:0]    r_tag;
    logic [stq_pkg::ID_W-1:0]     r_last_id;

    // output register
    logic                         r_ovalid;
    logic [stq_pkg::KIND_W-1:0]   r_okind;
    logic [stq_pkg::ID_W-1:0]     r_oid;
    logic [stq_pkg::TAG_W-1:0]    r_otag;
    logic                         r_ofound;
    logic                         r_olast;

    logic w_accept;
    logic w_slot_free;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_ovalid || i_m_tready;

    // cell chain wiring
    stq_pkg::t_cell_ctrl   w_ctrl;
    logic [TIME_WIDTH-1:0] w_key_time;
    logic [TIME_WIDTH-1:0] w_time [DEPTH];
    stq_pkg::t_cell_info   w_info [DEPTH];
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_flag;
    logic [DEPTH-1:0]      w_rm_sel;
    logic [stq_pkg::ID_W-1:0] w_nid;
    logic                  w_full;
    logic                  w_found;

    // result word built in the act cycle
    logic [stq_pkg::KIND_W-1:0] w_rkind;
    logic [stq_pkg::ID_W-1:0]   w_rid;
    logic [stq_pkg::TAG_W-1:0]  w_rtag;
    logic                       w_rfound;
    logic                       w_rlast;
    logic                       w_more;

    // next id wraps to 1, never 0
    assign w_nid   = (r_last_id == stq_pkg::ID_MAX) ? {{(stq_pkg::ID_W-1){1'b0}}, 1'b1}
                                                    : r_last_id + 1'b1;
    assign w_full  = w_valid[DEPTH-1];
    assign w_found = |w_flag;

    // every cell at or after the first id match takes its right neighbor;
    // m | -m sets all bits from the lowest set bit upward, zero if no match
    assign w_rm_sel = w_flag | (~w_flag + {{(DEPTH-1){1'b0}}, 1'b1});

    // compare key: tick time for tick, expiry time for set
    assign w_key_time = (i_s_tuser == stq_pkg::ACT_TICK) ? w_now : w_etime;

    // chain command for this cycle
    always_comb begin
        w_ctrl.op    = stq_pkg::OP_HOLD;
        w_ctrl.by_id = 1'b0;
        if (w_accept) begin
            // evaluate all cells in the cycle the word is taken
            w_ctrl.op    = stq_pkg::OP_EVAL;
            w_ctrl.by_id = (i_s_tuser == stq_pkg::ACT_CANCEL);
        end else if (r_state == S_ACT && w_slot_free) begin
            unique case (r_action)
                stq_pkg::ACT_SET: begin
                    if (!w_full) begin
                        w_ctrl.op = stq_pkg::OP_INSERT;
                    end
                end
                stq_pkg::ACT_CANCEL: begin
                    if (r_tid != '0) begin
                        w_ctrl.op = stq_pkg::OP_REMOVE;
                    end
                end
                stq_pkg::ACT_TICK: begin
                    if (w_flag[0]) begin
                        w_ctrl.op = stq_pkg::OP_POP;
                    end
                end
                stq_pkg::ACT_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [TIME_WIDTH-1:0] w_prev_time;
            stq_pkg::t_cell_info   w_prev;
            logic [TIME_WIDTH-1:0] w_next_time;
            stq_pkg::t_cell_info   w_next;

            if (gi == 0) begin : g_head
                // the head always sees a "keep" neighbor: insert lands here if it is later
                assign w_prev_time = '0;
                assign w_prev      = '{valid: 1'b0, flag: 1'b1, id: '0, tag: '0};
            end else begin : g_body
                assign w_prev_time = w_time[gi-1];
                assign w_prev      = w_info[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_next_time = '0;
                assign w_next      = '{valid: 1'b0, flag: 1'b0, id: '0, tag: '0};
            end else begin : g_inner
                assign w_next_time = w_time[gi+1];
                assign w_next      = w_info[gi+1];
            end

            stq_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_key_time  (w_key_time),
                .i_key_id    (w_in_id),
                .i_new_time  (r_etime),
                .i_new_id    (w_nid),
                .i_new_tag   (r_tag),
                .i_prev_time (w_prev_time),
                .i_prev      (w_prev),
                .i_next_time (w_next_time),
                .i_next      (w_next),
                .i_sel       (w_rm_sel[gi]),
                .o_time      (w_time[gi]),
                .o_info      (w_info[gi])
            );

            assign w_valid[gi] = w_info[gi].valid;
            assign w_flag[gi]  = w_info[gi].flag;
        end
    endgenerate

    // hold the accepted word for the act cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_s_tuser;
            r_etime  <= w_etime;
            r_tid    <= w_in_id;
            r_tag    <= w_in_tag;
        end
    end

    // result word for the latched action; unused fields stay zero
    always_comb begin
        w_rkind  = stq_pkg::KIND_NONE;
        w_rid    = '0;
        w_rtag   = '0;
        w_rfound = 1'b0;
        w_rlast  = 1'b1;
        w_more   = 1'b0;
        unique case (r_action)
            stq_pkg::ACT_SET: begin
                if (w_full) begin
                    w_rkind = stq_pkg::KIND_FULL;
                end else begin
                    w_rkind = stq_pkg::KIND_SET;
                    w_rid   = w_nid;
                end
            end
            stq_pkg::ACT_CANCEL: begin
                if (r_tid == '0) begin
                    w_rkind = stq_pkg::KIND_BADID;
                end else begin
                    w_rkind  = stq_pkg::KIND_CANCEL;
                    w_rfound = w_found;
                end
            end
            default: begin
                // tick: emit the head while it has expired
                if (w_flag[0]) begin
                    w_rkind = stq_pkg::KIND_EXPIRED;
                    w_rid   = w_info[0].id;
                    w_rtag  = w_info[0].tag;
                    w_rlast = !w_flag[1];
                    w_more  = w_flag[1];
                end
            end
        endcase
    end

    // sequencer: state, id counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_last_id <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_ovalid && i_m_tready) begin
                        r_ovalid <= 1'b0;
                    end
                    if (w_accept) begin
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    priority if (r_action == stq_pkg::ACT_NOP) begin
                        // unused action: drop silently
                        if (r_ovalid && i_m_tready) begin
                            r_ovalid <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end else if (w_slot_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= w_rkind;
                        r_oid    <= w_rid;
                        r_otag   <= w_rtag;
                        r_ofound <= w_rfound;
                        r_olast  <= w_rlast;
                        r_state  <= w_more ? S_ACT : S_IDLE;
                        if ((r_action == stq_pkg::ACT_SET) && !w_full) begin
                            r_last_id <= w_nid;
                        end
                    end else begin
                        // hold while the result register waits on the receiver
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_ofound, r_otag, r_oid};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    // pending timers always fill the chain from the head without holes
    `STQ_ASSERT_NOW(a_chain_packed, i_clk, i_rst_n, 1'b1,
        $onehot({1'b0, w_valid} + {{DEPTH{1'b0}}, 1'b1}))

    // a fresh id is never zero
    `STQ_ASSERT_NOW(a_set_id_nonzero, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser == stq_pkg::KIND_SET),
        o_m_tdata[stq_pkg::ID_W-1:0] != '0)

    // a set against a full chain reports full
    `STQ_ASSERT_NEXT(a_full_reported, i_clk, i_rst_n,
        (r_state == S_ACT) && (r_action == stq_pkg::ACT_SET) && w_slot_free && w_full,
        o_m_tvalid && (o_m_tuser == stq_pkg::KIND_FULL))

endmodule

// File: src/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell : one slot of the sorted timer chain
// Holds one timer and a compare flag; shifts with its neighbors on command.
// ----------------------------------------------------------------------------
module stq_cell #(
    parameter int TIME_WIDTH = stq_pkg::TIME_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  stq_pkg::t_cell_ctrl     i_ctrl,
    input  logic [TIME_WIDTH-1:0]   i_key_time,
    input  logic [stq_pkg::ID_W-1:0] i_key_id,
    input  logic [TIME_WIDTH-1:0]   i_new_time,
    input  logic [stq_pkg::ID_W-1:0] i_new_id,
    input  logic [stq_pkg::TAG_W-1:0] i_new_tag,
    input  logic [TIME_WIDTH-1:0]   i_prev_time,
    input  stq_pkg::t_cell_info     i_prev,
    input  logic [TIME_WIDTH-1:0]   i_next_time,
    input  stq_pkg::t_cell_info     i_next,
    input  logic                    i_sel,
    output logic [TIME_WIDTH-1:0]   o_time,
    output stq_pkg::t_cell_info     o_info
);

    logic                      r_valid, n_valid;
    logic                      r_flag, n_flag;
    logic [TIME_WIDTH-1:0]     r_time, n_time;
    logic [stq_pkg::ID_W-1:0]  r_id, n_id;
    logic [stq_pkg::TAG_W-1:0] r_tag, n_tag;

    always_comb begin
        n_valid = r_valid;
        n_flag  = r_flag;
        n_time  = r_time;
        n_id    = r_id;
        n_tag   = r_tag;
        unique case (i_ctrl.op)
            stq_pkg::OP_HOLD: begin
            end
            stq_pkg::OP_EVAL: begin
                if (i_ctrl.by_id) begin
                    n_flag = r_valid && (r_id == i_key_id);
                end else begin
                    n_flag = r_valid && (r_time <= i_key_time);
                end
            end
            stq_pkg::OP_INSERT: begin
                // flag = valid and not later than the new time: keep the slot
                if (!r_flag) begin
                    if (i_prev.flag) begin
                        n_valid = 1'b1;
                        n_time  = i_new_time;
                        n_id    = i_new_id;
                        n_tag   = i_new_tag;
                    end else begin
                        n_valid = i_prev.valid;
                        n_time  = i_prev_time;
                        n_id    = i_prev.id;
                        n_tag   = i_prev.tag;
                    end
                end
            end
            stq_pkg::OP_REMOVE: begin
                if (i_sel) begin
                    n_valid = i_next.valid;
                    n_flag  = i_next.flag;
                    n_time  = i_next_time;
                    n_id    = i_next.id;
                    n_tag   = i_next.tag;
                end
            end
            stq_pkg::OP_POP: begin
                n_valid = i_next.valid;
                n_flag  = i_next.flag;
                n_time  = i_next_time;
                n_id    = i_next.id;
                n_tag   = i_next.tag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flag  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_flag  <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_id   <= n_id;
        r_tag  <= n_tag;
    end

    assign o_time       = r_time;
    assign o_info.valid = r_valid;
    assign o_info.flag  = r_flag;
    assign o_info.id    = r_id;
    assign o_info.tag   = r_tag;

endmodule
